// File: rtl/tlcd_pkg.sv
// ----------------------------------------------------------------------------
// tlcd_pkg
// Shared types, constants and helpers for the text LCD serial frame encoder.
// ----------------------------------------------------------------------------
package tlcd_pkg;

    // display geometry
    localparam int CHARS_PER_ROW = 16;
    localparam int ROWS          = 4;

    localparam int KIND_W  = 2;
    localparam int VALUE_W = 8;
    localparam int ROW_W   = 2;
    localparam int TCOL_W  = 3;
    localparam int COL_W   = 4;
    localparam int FRAME_W = 24;

    // last column and row before the cursor wraps
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(CHARS_PER_ROW - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    // sync bytes and address command bases
    localparam logic [7:0] SYNC_CMD  = 8'hF8;
    localparam logic [7:0] SYNC_DATA = 8'hFA;
    localparam logic [7:0] NIB_MASK  = 8'hF0;
    localparam logic [7:0] ADDR_EVEN = 8'h80;
    localparam logic [7:0] ADDR_ODD  = 8'h90;
    localparam logic [7:0] ADDR_HALF = 8'h08;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR     = 2'd0,
        KIND_CURSOR   = 2'd1,
        KIND_RAW_CMD  = 2'd2,
        KIND_RAW_DATA = 2'd3
    } kind_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [ROW_W-1:0]   target_row;
        logic [TCOL_W-1:0]  target_col;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } cursor_t;

    // one or two frames produced by a request
    typedef struct packed {
        logic [FRAME_W-1:0] frame0;
        logic [FRAME_W-1:0] frame1;
        logic               two;
    } frame_pair_t;

    // sync byte, high nibble byte, low nibble byte
    function automatic logic [FRAME_W-1:0] make_frame(input logic [7:0] sync,
                                                      input logic [7:0] data);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = data & NIB_MASK;
        lo = {data[3:0], 4'h0};
        return {sync, hi, lo};
    endfunction

    // cursor address command byte for a row and a two-character column
    function automatic logic [7:0] address_byte(input logic [ROW_W-1:0]  row,
                                                input logic [TCOL_W-1:0] col2);
        logic [7:0] base;
        base = row[0] ? ADDR_ODD : ADDR_EVEN;
        return base + 8'(col2) + (row[1] ? ADDR_HALF : 8'h00);
    endfunction

endpackage

// File: rtl/tlcd_req_if.sv
// ----------------------------------------------------------------------------
// tlcd_req_if
// Request channel: valid/ready handshake carrying one display request.
// ----------------------------------------------------------------------------
interface tlcd_req_if
    import tlcd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [ROW_W-1:0]   target_row;
    logic [TCOL_W-1:0]  target_col;

    modport source (output valid, kind, value, target_row, target_col, input ready);
    modport sink   (input valid, kind, value, target_row, target_col, output ready);
endinterface

// File: rtl/tlcd_res_if.sv
// ----------------------------------------------------------------------------
// tlcd_res_if
// Result channel: valid/ready handshake carrying one serial frame.
// ----------------------------------------------------------------------------
interface tlcd_res_if
    import tlcd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame;
    logic               last;

    modport source (output valid, frame, last, input ready);
    modport sink   (input valid, frame, last, output ready);
endinterface

// File: rtl/tlcd_encode.sv
// ----------------------------------------------------------------------------
// tlcd_encode
// Frame packing and cursor update for one request, purely combinational.
// ----------------------------------------------------------------------------
module tlcd_encode
    import tlcd_pkg::*;
(
    input  item_t       item,
    input  cursor_t     cursor,
    output frame_pair_t frames,
    output cursor_t     cursor_next
);

    logic    wrap;
    cursor_t wrapped;

    // wrap to the start of the next row, and from the last row to the first
    always_comb
    begin
        wrap        = (cursor.col >= COL_LAST);
        wrapped.col = '0;
        wrapped.row = (cursor.row >= ROW_LAST) ? '0 : cursor.row + ROW_W'(1);
    end

    // frames and next cursor by request kind
    always_comb
    begin
        frames.frame0 = make_frame(SYNC_DATA, item.value);
        frames.frame1 = make_frame(SYNC_CMD, address_byte(wrapped.row, '0));
        frames.two    = 1'b0;
        cursor_next   = cursor;
        unique case (kind_t'(item.kind))
            KIND_CHAR:
            begin
                if (wrap)
                begin
                    frames.two  = 1'b1;
                    cursor_next = wrapped;
                end
                else
                begin
                    cursor_next.col = cursor.col + COL_W'(1);
                end
            end
            KIND_CURSOR:
            begin
                frames.frame0   = make_frame(SYNC_CMD,
                                             address_byte(item.target_row, item.target_col));
                cursor_next.row = item.target_row;
                cursor_next.col = {item.target_col, 1'b0};
            end
            KIND_RAW_CMD:
            begin
                frames.frame0 = make_frame(SYNC_CMD, item.value);
            end
            KIND_RAW_DATA:
            begin
                frames.frame0 = make_frame(SYNC_DATA, item.value);
            end
            default:
            begin
                frames.frame0 = make_frame(SYNC_DATA, item.value);
            end
        endcase
    end

endmodule

// File: rtl/text_lcd_serial_frame_encoder.sv
// ----------------------------------------------------------------------------
// text_lcd_serial_frame_encoder
// Turns display requests into 24-bit serial frames for a 4x16 text LCD and
// tracks the cursor, emitting an address command when a row wraps.
// ----------------------------------------------------------------------------
//  port | dir | transaction
//  -----+-----+----------------------------------------------------------
//  req  | in  | kind, value, target_row, target_col: one display request
//  res  | out | frame, last: one 24-bit serial frame, last on final frame
//
//  One request per cycle while the result side is ready; a wrapping character
//  takes two result transactions. A request goes through the input register,
//  then the result register. The result register can hold a stalled frame
//  while the input register takes the next request.
//  Reset clears both valid flags and sets the cursor to row 0, column 0.
// ----------------------------------------------------------------------------
module text_lcd_serial_frame_encoder
    import tlcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tlcd_req_if.sink    req,
    tlcd_res_if.source  res
);

    // input stage
    logic        in_valid_reg;
    item_t       item_reg;

    // result stage
    logic        res_valid_reg;
    logic        phase_reg;
    frame_pair_t pair_reg;

    cursor_t     cursor_reg;
    cursor_t     cursor_next;
    frame_pair_t pair_next;

    logic        in_accept;
    logic        res_last;
    logic        res_done;
    logic        advance;

    tlcd_encode u_encode (
        .item        (item_reg),
        .cursor      (cursor_reg),
        .frames      (pair_next),
        .cursor_next (cursor_next)
    );

    // handshake and stage movement
    always_comb
    begin
        res_last  = !pair_reg.two || phase_reg;
        res_done  = res_valid_reg && res.ready && res_last;
        advance   = !res_valid_reg || res_done;
        req.ready = !in_valid_reg || advance;
        in_accept = req.valid && req.ready;
    end

    // result channel outputs
    always_comb
    begin
        res.valid = res_valid_reg;
        res.frame = phase_reg ? pair_reg.frame1 : pair_reg.frame0;
        res.last  = res_last;
    end

    // control state and cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            cursor_reg    <= '0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
                phase_reg     <= 1'b0;
                if (in_valid_reg)
                    cursor_reg <= cursor_next;
            end
            else if (res_valid_reg && res.ready)
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.kind       <= req.kind;
            item_reg.value      <= req.value;
            item_reg.target_row <= req.target_row;
            item_reg.target_col <= req.target_col;
        end
        if (advance)
            pair_reg <= pair_next;
    end

    // second frame only ever follows a first one of the same request
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (res_valid_reg && pair_reg.two))
        else $error("second frame phase without a two-frame request");

    // after a non-final frame the final one is presented next
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && !res.last) |=> (res.valid && res.last))
        else $error("wrap address frame missing after character frame");

    // every frame starts with a valid sync byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.frame[23:16] == SYNC_CMD || res.frame[23:16] == SYNC_DATA))
        else $error("bad sync byte");

    // nibble bytes carry data in their upper four bits only
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.frame[11:8] == 4'h0 && res.frame[3:0] == 4'h0))
        else $error("nibble byte has low bits set");

    // cursor moves only when a request enters the result stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && in_valid_reg) |=> $stable(cursor_reg))
        else $error("cursor changed without a request");

endmodule

// File: sim/tb_text_lcd_serial_frame_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_lcd_serial_frame_encoder
// Self-checking bench for the text LCD serial frame encoder. A queue of
// display requests, directed corner cases followed by random cursor runs and
// noise, feeds a clocked driver; every accepted request is encoded by a local
// cursor model into expected frames, which a clocked monitor compares field by
// field against the frames leaving the block under random back-pressure.
// ----------------------------------------------------------------------------
module tb_text_lcd_serial_frame_encoder;
    import tlcd_pkg::*;

    localparam int  RANDOM_ITEMS = 1350;
    localparam int  CALM_TAIL    = 150;
    localparam int  CYCLE_LIMIT  = 300000;
    localparam int  DRAIN_CYCLES = 8;

    localparam logic [7:0] FRM_SYNC_CMD  = 8'hF8;
    localparam logic [7:0] FRM_SYNC_DATA = 8'hFA;

    typedef struct {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic [ROW_W-1:0]   row;
        logic [TCOL_W-1:0]  col;
        int                 pause;
    } lcd_request_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               last;
    } lcd_frame_t;

    logic clk;
    logic rst_n;

    tlcd_req_if req_bus ();
    tlcd_res_if res_bus ();

    lcd_request_t request_queue[$];
    lcd_frame_t   frame_queue[$];

    // cursor as the display sees it
    logic [ROW_W-1:0] model_row;
    logic [COL_W-1:0] model_col;

    lcd_request_t on_bus;
    lcd_request_t next_req;
    bit           next_loaded;
    int           gap_left;
    int           stall_left;
    bit           stall_mode;
    int           mode_timer;
    int           error_count = 0;
    int           cycle_count = 0;

    text_lcd_serial_frame_encoder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [FRAME_W-1:0] got,
                                   input logic [FRAME_W-1:0] want);
        $display("ERROR %0t: %0s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // 24-bit frame: sync, high nibble in upper half, low nibble in upper half
    function automatic logic [FRAME_W-1:0] pack_frame(input logic [7:0] sync,
                                                      input logic [7:0] b);
        return {sync, b[7:4], 4'h0, b[3:0], 4'h0};
    endfunction

    // DDRAM address command: 1 0 0 row[0] row[1] col2
    function automatic logic [7:0] row_address(input logic [ROW_W-1:0] row,
                                               input logic [TCOL_W-1:0] col2);
        return {3'b100, row[0], row[1], col2};
    endfunction

    // encode one accepted request and advance the cursor
    task automatic encode_request(input lcd_request_t r);
        lcd_frame_t f;
        bit         wraps;
        case (r.kind)
            KIND_CHAR:
            begin
                wraps = (int'(model_col) >= CHARS_PER_ROW - 1);
                f.frame = pack_frame(FRM_SYNC_DATA, r.value);
                f.last  = !wraps;
                frame_queue.push_back(f);
                if (wraps)
                begin
                    model_col = '0;
                    if (int'(model_row) >= ROWS - 1)
                        model_row = '0;
                    else
                        model_row = model_row + ROW_W'(1);
                    f.frame = pack_frame(FRM_SYNC_CMD, row_address(model_row, '0));
                    f.last  = 1'b1;
                    frame_queue.push_back(f);
                end
                else
                begin
                    model_col = model_col + COL_W'(1);
                end
            end
            KIND_CURSOR:
            begin
                model_row = r.row;
                model_col = {r.col, 1'b0};
                f.frame = pack_frame(FRM_SYNC_CMD, row_address(r.row, r.col));
                f.last  = 1'b1;
                frame_queue.push_back(f);
            end
            KIND_RAW_CMD:
            begin
                f.frame = pack_frame(FRM_SYNC_CMD, r.value);
                f.last  = 1'b1;
                frame_queue.push_back(f);
            end
            default:
            begin
                f.frame = pack_frame(FRM_SYNC_DATA, r.value);
                f.last  = 1'b1;
                frame_queue.push_back(f);
            end
        endcase
    endtask

    // queue a request, optionally preceded by an idle burst
    task automatic queue_request(input kind_t k, input logic [7:0] v,
                                 input logic [ROW_W-1:0] row, input logic [TCOL_W-1:0] col,
                                 input bit gappy);
        lcd_request_t r;
        r.kind  = k;
        r.value = v;
        r.row   = row;
        r.col   = col;
        r.pause = (gappy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        request_queue.push_back(r);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid      <= 1'b0;
            req_bus.kind       <= '0;
            req_bus.value      <= '0;
            req_bus.target_row <= '0;
            req_bus.target_col <= '0;
            next_loaded = 1'b0;
            gap_left    = 0;
            model_row   = '0;
            model_col   = '0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                encode_request(on_bus);
            // hold a stalled transaction, otherwise pick the next one
            if (!(req_bus.valid && !req_bus.ready))
            begin
                if (!next_loaded && request_queue.size() > 0)
                begin
                    next_req    = request_queue.pop_front();
                    gap_left    = next_req.pause;
                    next_loaded = 1'b1;
                end
                if (next_loaded && gap_left == 0)
                begin
                    req_bus.valid      <= 1'b1;
                    req_bus.kind       <= next_req.kind;
                    req_bus.value      <= next_req.value;
                    req_bus.target_row <= next_req.row;
                    req_bus.target_col <= next_req.col;
                    on_bus      = next_req;
                    next_loaded = 1'b0;
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // frame monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        lcd_frame_t want;
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
            stall_left = 0;
            stall_mode = 1'b0;
            mode_timer = 0;
        end
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (frame_queue.size() == 0)
                begin
                    report_mismatch("unexpected frame", res_bus.frame, '0);
                end
                else
                begin
                    want = frame_queue.pop_front();
                    if (res_bus.frame !== want.frame)
                        report_mismatch("frame", res_bus.frame, want.frame);
                    if (res_bus.last !== want.last)
                        report_mismatch("last", FRAME_W'(res_bus.last), FRAME_W'(want.last));
                end
            end
            // switch between stalling and free-running stretches
            if (mode_timer == 0)
            begin
                stall_mode = ($urandom_range(0, 2) != 0);
                mode_timer = $urandom_range(50, 300);
            end
            else
            begin
                mode_timer--;
            end
            if (stall_left > 0)
            begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (stall_mode && request_queue.size() > CALM_TAIL &&
                     $urandom_range(0, 3) == 0)
            begin
                res_bus.ready <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end
            else
            begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL text_lcd_serial_frame_encoder");
            $finish;
        end
    end

    // stimulus and end of test
    initial
    begin
        int  n;
        int  run_len;
        int  run_choice;
        bit  gappy;
        int  k;

        rst_n = 1'b0;

        // row wraps from the last column of every row, last row back to first
        for (k = 0; k < ROWS; k++)
        begin
            queue_request(KIND_CURSOR, 8'h00, ROW_W'(k), 3'd7, 1'b0);
            queue_request(KIND_CHAR, 8'h41, 2'd3, 3'd0, 1'b0);
            queue_request(KIND_CHAR, 8'hFF, 2'd0, 3'd7, 1'b0);
        end
        // value extremes on every kind
        queue_request(KIND_CURSOR, 8'hFF, 2'd0, 3'd0, 1'b0);
        queue_request(KIND_CHAR, 8'h00, 2'd0, 3'd0, 1'b0);
        queue_request(KIND_CHAR, 8'hFF, 2'd3, 3'd7, 1'b0);
        queue_request(KIND_RAW_CMD, 8'h00, 2'd0, 3'd0, 1'b0);
        queue_request(KIND_RAW_CMD, 8'hFF, 2'd3, 3'd7, 1'b0);
        queue_request(KIND_RAW_DATA, 8'h00, 2'd0, 3'd0, 1'b0);
        queue_request(KIND_RAW_DATA, 8'hFF, 2'd3, 3'd7, 1'b0);
        // raw items leave the cursor alone at the wrap point
        queue_request(KIND_CURSOR, 8'h5A, 2'd3, 3'd7, 1'b0);
        queue_request(KIND_RAW_DATA, 8'hA5, 2'd1, 3'd2, 1'b0);
        queue_request(KIND_CHAR, 8'h5A, 2'd2, 3'd5, 1'b0);
        queue_request(KIND_CHAR, 8'hA5, 2'd1, 3'd6, 1'b0);

        // random cursor runs with character bursts, plus single noise items
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            run_choice = $urandom_range(0, 3);
            gappy      = ($urandom_range(0, 2) != 0) && (n < RANDOM_ITEMS - CALM_TAIL);
            if (run_choice == 0)
            begin
                queue_request(kind_t'($urandom_range(0, 3)), 8'($urandom),
                              ROW_W'($urandom), TCOL_W'($urandom), gappy);
                n++;
            end
            else
            begin
                queue_request(KIND_CURSOR, 8'($urandom), ROW_W'($urandom),
                              TCOL_W'($urandom), gappy);
                n++;
                run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40)
                                                      : $urandom_range(2, 18);
                for (k = 0; k < run_len; k++)
                begin
                    queue_request(($urandom_range(0, 9) == 0) ? KIND_RAW_DATA : KIND_CHAR,
                                  8'($urandom), ROW_W'($urandom), TCOL_W'($urandom), gappy);
                    n++;
                end
            end
        end

        repeat (3) @(posedge clk);
        rst_n = 1'b1;

        // all requests out, then all frames back
        @(negedge clk);
        while (request_queue.size() > 0 || next_loaded || req_bus.valid)
            @(negedge clk);
        while (frame_queue.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("PASS text_lcd_serial_frame_encoder");
        else
            $display("FAIL text_lcd_serial_frame_encoder");
        $finish;
    end

endmodule
